FILE: hw/rtl/tpf_pkg.sv
// ----------------------------------------------------------------------------
// tpf_pkg
// Shared types and constants for the Ethernet/IPv4/TCP port filter.
// ----------------------------------------------------------------------------
package tpf_pkg;

  // Default frame length limit (bytes past it are not captured)
  localparam int unsigned MAX_FRAME_BYTES_DEF = 65536;

  // Field widths
  localparam int unsigned LEN_W     = 17;
  localparam int unsigned CFG_IDX_W = 8;

  // Header layout and protocol constants
  localparam int unsigned ETH_HDR_BYTES  = 14;
  localparam int unsigned MIN_NET_BYTES  = 34;
  localparam int unsigned TCP_HDR_BYTES  = 20;
  localparam int unsigned ETYPE_HI_POS   = 12;
  localparam int unsigned ETYPE_LO_POS   = 13;
  localparam int unsigned VL_POS         = 14;
  localparam int unsigned PROTO_POS      = 23;
  localparam int unsigned TCP_DOFF_POS   = 12;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  VERSION_MASK   = 8'hF0;
  localparam logic [7:0]  VERSION_IPV4   = 8'h40;
  localparam logic [7:0]  IHL_MASK       = 8'h0F;
  localparam logic [7:0]  IPPROTO_TCP    = 8'd6;
  localparam logic [15:0] DEFAULT_PORT   = 16'd80;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WANTED_PORT     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WANTED_PROTOCOL = CFG_IDX_W'(1);

  // Verdict codes, in check order
  typedef enum logic [3:0] {
    VERDICT_OK        = 4'd0,
    VERDICT_SHORT     = 4'd1,
    VERDICT_ETHERTYPE = 4'd2,
    VERDICT_VERSION   = 4'd3,
    VERDICT_PROTOCOL  = 4'd4,
    VERDICT_SHORT_TCP = 4'd5,
    VERDICT_ZERO_DOFF = 4'd6,
    VERDICT_PORT      = 4'd7,
    VERDICT_EMPTY     = 4'd8
  } verdict_t;

  // Header fields of a frame as seen after its final byte
  typedef struct packed {
    logic [LEN_W-1:0] frame_len;
    logic [15:0]      ether_type;
    logic [7:0]       version_length;
    logic [7:0]       protocol;
    logic [15:0]      source_port;
    logic [15:0]      dest_port;
    logic [7:0]       tcp_offset;
  } hdr_t;

endpackage

FILE: hw/rtl/tpf_capture.sv
// ----------------------------------------------------------------------------
// tpf_capture
// Input register, byte counter and header field capture for one frame.
// ----------------------------------------------------------------------------
module tpf_capture #(
  parameter int unsigned MAX_FRAME_BYTES = tpf_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   in_frame_byte,
  input  logic         in_last_byte,
  input  logic         res_free,
  output logic         frame_done,
  output tpf_pkg::hdr_t hdr
);

  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);

  // Input register
  logic       vld_r;
  logic [7:0] byte_r;
  logic       last_r;

  // Per-frame state
  logic [POS_W-1:0] pos_r;
  logic [15:0]      etype_r;
  logic [7:0]       vl_r;
  logic [7:0]       proto_r;
  logic [15:0]      sport_r;
  logic [15:0]      dport_r;
  logic [7:0]       toff_r;

  logic [POS_W-1:0] pos_nxt;
  logic [15:0]      etype_nxt;
  logic [7:0]       vl_nxt;
  logic [7:0]       proto_nxt;
  logic [15:0]      sport_nxt;
  logic [15:0]      dport_nxt;
  logic [7:0]       toff_nxt;

  logic                      fire;
  logic                      load;
  logic                      in_range;
  logic [tpf_pkg::LEN_W-1:0] pos_x;
  logic [7:0]                vl_eff;
  logic [7:0]                ts;

  // A held byte moves on unless it is a final byte and the result slot is busy
  assign fire       = vld_r && (!last_r || res_free);
  assign load       = !vld_r || fire;
  assign in_stall   = !load;
  assign frame_done = fire && last_r;

  // Capture next values
  always_comb begin
    in_range  = pos_r < POS_W'(MAX_FRAME_BYTES);
    pos_x     = tpf_pkg::LEN_W'(pos_r);
    vl_eff    = (pos_x == tpf_pkg::LEN_W'(tpf_pkg::VL_POS)) ? byte_r : vl_r;
    ts        = 8'(tpf_pkg::ETH_HDR_BYTES) + {2'b00, (vl_eff & tpf_pkg::IHL_MASK) , 2'b00}[7:0];
    pos_nxt   = pos_r;
    etype_nxt = etype_r;
    vl_nxt    = vl_r;
    proto_nxt = proto_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    toff_nxt  = toff_r;
    if (in_range) begin
      pos_nxt = pos_r + POS_W'(1);
      if (pos_x == tpf_pkg::LEN_W'(tpf_pkg::ETYPE_HI_POS)) etype_nxt[15:8] = byte_r;
      if (pos_x == tpf_pkg::LEN_W'(tpf_pkg::ETYPE_LO_POS)) etype_nxt[7:0] = byte_r;
      if (pos_x == tpf_pkg::LEN_W'(tpf_pkg::VL_POS)) vl_nxt = byte_r;
      if (pos_x == tpf_pkg::LEN_W'(tpf_pkg::PROTO_POS)) proto_nxt = byte_r;
      // TCP header fields, placed from the IP header length
      if (pos_x >= tpf_pkg::LEN_W'(tpf_pkg::VL_POS)) begin
        if (pos_x == tpf_pkg::LEN_W'(ts)) sport_nxt[15:8] = byte_r;
        if (pos_x == tpf_pkg::LEN_W'(ts + 8'd1)) sport_nxt[7:0] = byte_r;
        if (pos_x == tpf_pkg::LEN_W'(ts + 8'd2)) dport_nxt[15:8] = byte_r;
        if (pos_x == tpf_pkg::LEN_W'(ts + 8'd3)) dport_nxt[7:0] = byte_r;
        if (pos_x == tpf_pkg::LEN_W'(ts + 8'(tpf_pkg::TCP_DOFF_POS))) toff_nxt = byte_r;
      end
    end
  end

  // Header view including the byte in flight
  assign hdr.frame_len      = tpf_pkg::LEN_W'(pos_nxt);
  assign hdr.ether_type     = etype_nxt;
  assign hdr.version_length = vl_nxt;
  assign hdr.protocol       = proto_nxt;
  assign hdr.source_port    = sport_nxt;
  assign hdr.dest_port      = dport_nxt;
  assign hdr.tcp_offset     = toff_nxt;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_frame_byte;
      last_r <= in_last_byte;
    end
  end

  // Frame state, cleared after each final byte
  always_ff @(posedge clk) begin
    if (!rst_n || frame_done) begin
      pos_r   <= '0;
      etype_r <= '0;
      vl_r    <= '0;
      proto_r <= '0;
      sport_r <= '0;
      dport_r <= '0;
      toff_r  <= '0;
    end else if (fire) begin
      pos_r   <= pos_nxt;
      etype_r <= etype_nxt;
      vl_r    <= vl_nxt;
      proto_r <= proto_nxt;
      sport_r <= sport_nxt;
      dport_r <= dport_nxt;
      toff_r  <= toff_nxt;
    end
  end

endmodule

FILE: hw/rtl/tpf_verdict.sv
// ----------------------------------------------------------------------------
// tpf_verdict
// Header checks on the final byte and the result register.
// ----------------------------------------------------------------------------
module tpf_verdict (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      frame_done,
  input  tpf_pkg::hdr_t             hdr,
  input  logic [15:0]               wanted_port,
  input  logic [7:0]                wanted_protocol,
  output logic                      res_free,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_accepted,
  output logic [3:0]                out_verdict_code,
  output logic [tpf_pkg::LEN_W-1:0] out_payload_offset,
  output logic [tpf_pkg::LEN_W-1:0] out_payload_length
);

  localparam int unsigned REM_W = tpf_pkg::LEN_W + 2;

  logic                      valid_r;
  tpf_pkg::verdict_t         code_r;
  logic [tpf_pkg::LEN_W-1:0] poff_r;
  logic [tpf_pkg::LEN_W-1:0] plen_r;

  tpf_pkg::verdict_t         code_nxt;
  logic [tpf_pkg::LEN_W-1:0] poff_nxt;
  logic [tpf_pkg::LEN_W-1:0] plen_nxt;
  logic [6:0]                ihl4;
  logic [6:0]                doff4;
  logic [REM_W-1:0]          rem;
  logic [REM_W-1:0]          rem2;
  logic                      rem_short;

  assign res_free = !valid_r || !out_stall;

  // Check chain: first failing check wins
  always_comb begin
    ihl4      = {hdr.version_length[3:0], 2'b00} & {tpf_pkg::IHL_MASK[4:0], 2'b11};
    doff4     = {hdr.tcp_offset[7:4], 2'b00};
    rem       = REM_W'(hdr.frame_len) - REM_W'(tpf_pkg::ETH_HDR_BYTES) - REM_W'(ihl4);
    rem2      = rem - REM_W'(doff4);
    rem_short = rem[REM_W-1] || (rem < REM_W'(tpf_pkg::TCP_HDR_BYTES));
    code_nxt  = tpf_pkg::VERDICT_OK;
    poff_nxt  = '0;
    plen_nxt  = '0;
    if (hdr.frame_len < tpf_pkg::LEN_W'(tpf_pkg::MIN_NET_BYTES)) begin
      code_nxt = tpf_pkg::VERDICT_SHORT;
    end else if (hdr.ether_type != tpf_pkg::ETHERTYPE_IPV4) begin
      code_nxt = tpf_pkg::VERDICT_ETHERTYPE;
    end else if ((hdr.version_length & tpf_pkg::VERSION_MASK) != tpf_pkg::VERSION_IPV4) begin
      code_nxt = tpf_pkg::VERDICT_VERSION;
    end else if (hdr.protocol != wanted_protocol) begin
      code_nxt = tpf_pkg::VERDICT_PROTOCOL;
    end else if (rem_short) begin
      code_nxt = tpf_pkg::VERDICT_SHORT_TCP;
    end else if (doff4 == 7'd0) begin
      code_nxt = tpf_pkg::VERDICT_ZERO_DOFF;
    end else if (hdr.source_port != wanted_port && hdr.dest_port != wanted_port) begin
      code_nxt = tpf_pkg::VERDICT_PORT;
    end else if (rem2[REM_W-1]) begin
      // TCP header runs past the frame end
      code_nxt = tpf_pkg::VERDICT_SHORT_TCP;
    end else if (rem2 == '0) begin
      code_nxt = tpf_pkg::VERDICT_EMPTY;
    end else begin
      poff_nxt = tpf_pkg::LEN_W'(tpf_pkg::ETH_HDR_BYTES) + tpf_pkg::LEN_W'(ihl4)
               + tpf_pkg::LEN_W'(doff4);
      plen_nxt = rem2[tpf_pkg::LEN_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_free) begin
      valid_r <= frame_done;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && frame_done) begin
      code_r <= code_nxt;
      poff_r <= poff_nxt;
      plen_r <= plen_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_accepted       = (code_r == tpf_pkg::VERDICT_OK);
  assign out_verdict_code   = code_r;
  assign out_payload_offset = poff_r;
  assign out_payload_length = plen_r;

endmodule

FILE: hw/rtl/ethernet_ipv4_tcp_port_filter_top.sv
// ----------------------------------------------------------------------------
// ethernet_ipv4_tcp_port_filter_top
// Byte-stream Ethernet/IPv4/TCP header filter with a port and protocol match.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, but a final byte stalls while the result
//   register is full; the input register and the result register each hold
//   one request, so bytes keep flowing while a verdict waits.
// Reset: synchronous active-low rst_n clears the frame state and both valids;
//   wanted_port returns to 80 and wanted_protocol to 6.
// ----------------------------------------------------------------------------
module ethernet_ipv4_tcp_port_filter_top #(
  parameter int unsigned MAX_FRAME_BYTES = tpf_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // byte input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_frame_byte,
  input  logic                         in_last_byte,
  // verdict output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_accepted,
  output logic [3:0]                   out_verdict_code,
  output logic [tpf_pkg::LEN_W-1:0]    out_payload_offset,
  output logic [tpf_pkg::LEN_W-1:0]    out_payload_length,
  // register writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                  cfg_data
);

  logic [15:0]   wanted_port_r;
  logic [7:0]    wanted_protocol_r;
  logic          res_free;
  logic          frame_done;
  tpf_pkg::hdr_t hdr;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_port_r     <= tpf_pkg::DEFAULT_PORT;
      wanted_protocol_r <= tpf_pkg::IPPROTO_TCP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpf_pkg::CFG_WANTED_PORT:     wanted_port_r     <= cfg_data;
        tpf_pkg::CFG_WANTED_PROTOCOL: wanted_protocol_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  tpf_capture #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_capture (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_frame_byte (in_frame_byte),
    .in_last_byte  (in_last_byte),
    .res_free      (res_free),
    .frame_done    (frame_done),
    .hdr           (hdr)
  );

  tpf_verdict u_verdict (
    .clk                (clk),
    .rst_n              (rst_n),
    .frame_done         (frame_done),
    .hdr                (hdr),
    .wanted_port        (wanted_port_r),
    .wanted_protocol    (wanted_protocol_r),
    .res_free           (res_free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_accepted       (out_accepted),
    .out_verdict_code   (out_verdict_code),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length)
  );

endmodule
